// File: src/sdms_pkg.sv
// Package for the step/direction move sequencer.
// Holds the phase codes, configuration register indexes and reset defaults.
// No dependencies.
package sdms_pkg;

  // Move sequence phases.
  localparam logic [1:0] PH_FWD_MOVE    = 2'd0;
  localparam logic [1:0] PH_PAUSE       = 2'd1;
  localparam logic [1:0] PH_REV_MOVE    = 2'd2;
  localparam logic [1:0] PH_FINAL_PAUSE = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_WIDTH = 3;
  localparam int unsigned CFG_DATA_WIDTH  = 32;

  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;

  localparam cfg_index_t REG_STEP_HIGH   = 3'd0;
  localparam cfg_index_t REG_STEP_LOW    = 3'd1;
  localparam cfg_index_t REG_PULSES      = 3'd2;
  localparam cfg_index_t REG_PAUSE_BEFORE = 3'd3;
  localparam cfg_index_t REG_PAUSE_AFTER = 3'd4;
  localparam cfg_index_t REG_JOG_INTERVAL = 3'd5;

  // Register reset values.
  localparam logic [9:0]  STEP_HIGH_RESET    = 10'd5;
  localparam logic [15:0] STEP_LOW_RESET     = 16'd307;
  localparam logic [15:0] PULSES_RESET       = 16'd6400;
  localparam logic [31:0] PAUSE_BEFORE_RESET = 32'd1000000;
  localparam logic [31:0] PAUSE_AFTER_RESET  = 32'd5000000;
  localparam logic [31:0] JOG_INTERVAL_RESET = 32'd100000;

endpackage

// File: src/step_dir_move_sequencer.sv
// Step/direction move sequencer: forward move, pause, reverse move, final
// pause with alternating jog pulses. Depends on sdms_pkg.
//
// The result of an accepted input transaction is registered and shown in the next cycle.
// Throughput: one input transaction per cycle; all sequencing for a tick is
// done in one pass of logic between the state registers and the result
// register, so the only limit is back pressure on the result channel.
// Reset (rst, synchronous): configuration returns to its defaults, the
// sequence restarts at the forward move with position zero, no result held.
module step_dir_move_sequencer #(
  parameter int unsigned TIMER_WIDTH    = 32,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      tick,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      step_level,
  output logic                      dir_level,
  output logic signed [31:0]        position,
  output logic [1:0]                phase,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  sdms_pkg::cfg_index_t      cfg_index,
  input  sdms_pkg::cfg_data_t       cfg_data
);
  import sdms_pkg::*;

  // Saturating increment for the pause and jog timers.
  function automatic logic [TIMER_WIDTH-1:0] timer_inc(input logic [TIMER_WIDTH-1:0] t);
    timer_inc = (&t) ? t : t + TIMER_WIDTH'(1);
  endfunction

  // A timer has run out at its limit or at its maximum.
  function automatic logic timer_done(input logic [TIMER_WIDTH-1:0] t,
                                      input logic [31:0] limit);
    timer_done = (&t) || ({32'b0, t} >= {{TIMER_WIDTH{1'b0}}, limit});
  endfunction

  // Configuration registers.
  logic [9:0]  step_high_ticks;
  logic [15:0] step_low_ticks;
  logic [15:0] pulses_per_move;
  logic [31:0] pause_before_ticks;
  logic [31:0] pause_after_ticks;
  logic [31:0] jog_interval_ticks;

  // Sequencer state.
  logic [1:0]                phase_reg, phase_reg_next;
  logic                      pulse_high, pulse_high_next;
  logic [15:0]               phase_timer, phase_timer_next;
  logic [15:0]               pulse_counter, pulse_counter_next;
  logic [TIMER_WIDTH-1:0]    pause_timer, pause_timer_next;
  logic [TIMER_WIDTH-1:0]    jog_timer, jog_timer_next;
  logic                      jog_active, jog_active_next;
  logic                      jog_first, jog_first_next;
  logic                      jog_direction, jog_direction_next;
  logic [POSITION_WIDTH-1:0] position_reg, position_reg_next;

  // State after a possible jog start on this tick.
  logic        jog_start;
  logic        eff_pulse_high;
  logic [15:0] eff_phase_timer;
  logic        eff_jog_active;
  logic        eff_jog_direction;

  // Pulse timing results.
  logic [15:0] pulse_limit;
  logic [16:0] phase_timer_inc;
  logic        pulse_phase_end;
  logic        pulse_done;
  logic [15:0] pulse_counter_inc;
  logic [TIMER_WIDTH-1:0] pause_timer_inc;
  logic [POSITION_WIDTH+31:0] position_ext;

  logic in_accept;
  logic res_step;
  logic res_dir;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_high_ticks    <= STEP_HIGH_RESET;
      step_low_ticks     <= STEP_LOW_RESET;
      pulses_per_move    <= PULSES_RESET;
      pause_before_ticks <= PAUSE_BEFORE_RESET;
      pause_after_ticks  <= PAUSE_AFTER_RESET;
      jog_interval_ticks <= JOG_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_HIGH:    step_high_ticks    <= cfg_data[9:0];
        REG_STEP_LOW:     step_low_ticks     <= cfg_data[15:0];
        REG_PULSES:       pulses_per_move    <= cfg_data[15:0];
        REG_PAUSE_BEFORE: pause_before_ticks <= cfg_data;
        REG_PAUSE_AFTER:  pause_after_ticks  <= cfg_data;
        REG_JOG_INTERVAL: jog_interval_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // A jog starts on a tick of the final pause when none is active and
  // either it is the first one of the phase or the interval has run out.
  always_comb begin
    jog_start = tick && (phase_reg == PH_FINAL_PAUSE) && !jog_active &&
                (jog_first || timer_done(jog_timer, jog_interval_ticks));
    eff_pulse_high    = jog_start ? 1'b1  : pulse_high;
    eff_phase_timer   = jog_start ? 16'd0 : phase_timer;
    eff_jog_active    = jog_active || jog_start;
    eff_jog_direction = jog_start ? !jog_direction : jog_direction;
  end

  // Pin levels for the tick being consumed.
  always_comb begin
    unique case (phase_reg)
      PH_FWD_MOVE: begin
        res_step = eff_pulse_high;
        res_dir  = 1'b1;
      end
      PH_PAUSE: begin
        res_step = 1'b0;
        res_dir  = 1'b1;
      end
      PH_REV_MOVE: begin
        res_step = eff_pulse_high;
        res_dir  = 1'b0;
      end
      default: begin
        res_step = eff_jog_active && eff_pulse_high;
        res_dir  = eff_jog_direction;
      end
    endcase
  end

  // One tick of the current pulse: high part, then low part.
  always_comb begin
    pulse_limit     = eff_pulse_high ? {6'b0, step_high_ticks} : step_low_ticks;
    phase_timer_inc = {1'b0, eff_phase_timer} + 17'd1;
    pulse_phase_end = phase_timer_inc >= {1'b0, pulse_limit};
    pulse_done      = pulse_phase_end && !eff_pulse_high;
    pulse_counter_inc = pulse_counter + 16'd1;
    pause_timer_inc   = timer_inc(pause_timer);
  end

  // Next state for a tick.
  always_comb begin
    phase_reg_next     = phase_reg;
    pulse_high_next    = eff_pulse_high;
    phase_timer_next   = eff_phase_timer;
    pulse_counter_next = pulse_counter;
    pause_timer_next   = pause_timer;
    jog_timer_next     = jog_timer;
    jog_active_next    = eff_jog_active;
    jog_first_next     = jog_start ? 1'b0 : jog_first;
    jog_direction_next = eff_jog_direction;
    position_reg_next  = position_reg;

    unique case (phase_reg)
      PH_FWD_MOVE, PH_REV_MOVE: begin
        pulse_high_next  = pulse_phase_end ? !eff_pulse_high : eff_pulse_high;
        phase_timer_next = pulse_phase_end ? 16'd0 : phase_timer_inc[15:0];
        if (pulse_done) begin
          position_reg_next = (phase_reg == PH_FWD_MOVE) ?
                              position_reg + POSITION_WIDTH'(1) :
                              position_reg - POSITION_WIDTH'(1);
          pulse_counter_next = pulse_counter_inc;
          if (pulse_counter_inc >= pulses_per_move || pulse_counter_inc == 16'd0) begin
            pause_timer_next = '0;
            if (phase_reg == PH_FWD_MOVE) begin
              phase_reg_next = PH_PAUSE;
            end else begin
              phase_reg_next = PH_FINAL_PAUSE;
              jog_first_next = 1'b1;
            end
          end
        end
      end
      PH_PAUSE: begin
        pause_timer_next = pause_timer_inc;
        if (timer_done(pause_timer_inc, pause_before_ticks)) begin
          phase_reg_next     = PH_REV_MOVE;
          pulse_counter_next = 16'd0;
          pulse_high_next    = 1'b1;
          phase_timer_next   = 16'd0;
        end
      end
      default: begin
        pause_timer_next = pause_timer_inc;
        if (eff_jog_active) begin
          pulse_high_next  = pulse_phase_end ? !eff_pulse_high : eff_pulse_high;
          phase_timer_next = pulse_phase_end ? 16'd0 : phase_timer_inc[15:0];
          if (pulse_done) begin
            position_reg_next = eff_jog_direction ?
                                position_reg + POSITION_WIDTH'(1) :
                                position_reg - POSITION_WIDTH'(1);
            jog_active_next = 1'b0;
            jog_timer_next  = '0;
          end
        end else begin
          jog_timer_next = timer_inc(jog_timer);
        end
        // The final pause ends only once no jog is in flight.
        if (!jog_active_next && timer_done(pause_timer_inc, pause_after_ticks)) begin
          phase_reg_next     = PH_FWD_MOVE;
          pulse_counter_next = 16'd0;
          pulse_high_next    = 1'b1;
          phase_timer_next   = 16'd0;
        end
      end
    endcase
  end

  // State registers advance only on an accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_FWD_MOVE;
      pulse_high    <= 1'b1;
      phase_timer   <= 16'd0;
      pulse_counter <= 16'd0;
      pause_timer   <= '0;
      jog_timer     <= '0;
      jog_active    <= 1'b0;
      jog_first     <= 1'b1;
      jog_direction <= 1'b0;
      position_reg  <= '0;
    end else if (in_accept && tick) begin
      phase_reg     <= phase_reg_next;
      pulse_high    <= pulse_high_next;
      phase_timer   <= phase_timer_next;
      pulse_counter <= pulse_counter_next;
      pause_timer   <= pause_timer_next;
      jog_timer     <= jog_timer_next;
      jog_active    <= jog_active_next;
      jog_first     <= jog_first_next;
      jog_direction <= jog_direction_next;
      position_reg  <= position_reg_next;
    end
  end

  // Result register: low 32 bits of the position, zero filled when narrower.
  assign position_ext = {32'b0, position_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      step_level <= res_step;
      dir_level  <= res_dir;
      position   <= signed'(position_ext[31:0]);
      phase      <= phase_reg;
    end
  end

endmodule

// File: tb/sv/step_dir_move_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the step/direction move sequencer.
// Drives tick transactions and register writes, predicts the step, direction,
// position and phase of every tick, and checks them. Depends on sdms_pkg.
module step_dir_move_sequencer_test;
  import sdms_pkg::*;

  localparam cfg_index_t FIRST_UNUSED_REG = REG_JOG_INTERVAL + 3'd1;
  localparam int unsigned RANDOM_ITEMS = 1870;
  localparam int unsigned MAX_IDLE = 16;

  // Pin state that the sequencer reports for one tick.
  typedef struct {
    logic               step;
    logic               dir;
    logic signed [31:0] pos;
    logic [1:0]         ph;
  } pin_state_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic tick;
  logic out_valid;
  logic out_stall;
  logic step_level;
  logic dir_level;
  logic signed [31:0] position;
  logic [1:0] phase;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  cfg_data_t cfg_data;

  // Register copies held by the predictor.
  logic [9:0]  set_high;
  logic [15:0] set_low;
  logic [15:0] set_pulses;
  logic [31:0] set_pause_pre;
  logic [31:0] set_pause_post;
  logic [31:0] set_jog_gap;

  // Sequencer state held by the predictor.
  logic [1:0]  seq_phase;
  logic        pulse_hi;
  logic [15:0] pulse_timer;
  logic [15:0] pulse_count;
  logic [31:0] pause_count;
  logic [31:0] jog_count;
  logic        jog_on;
  logic        jog_due;
  logic        jog_fwd;
  logic [31:0] pos_count;

  pin_state_t pin_state_q[$];
  pin_state_t want_pins;

  bit gaps_on;
  bit stalls_on;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned idle_items;
  int unsigned writes_done;
  int unsigned cycles_done;
  int unsigned jogs_done;

  step_dir_move_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tick      (tick),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .step_level(step_level),
    .dir_level (dir_level),
    .position  (position),
    .phase     (phase),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Saturating timer increment.
  function automatic logic [31:0] timer_inc(logic [31:0] t);
    return (t == '1) ? t : t + 32'd1;
  endfunction

  // A timer has run out at its limit or at its maximum.
  function automatic bit timer_done(logic [31:0] t, logic [31:0] limit);
    return (t >= limit) || (t == '1);
  endfunction

  // One tick of the current pulse; true when its low part has just ended.
  function automatic bit pulse_advance();
    logic [31:0] lim;
    logic [31:0] nxt;
    lim = pulse_hi ? 32'(set_high) : 32'(set_low);
    nxt = 32'(pulse_timer) + 32'd1;
    if (nxt >= lim) begin
      pulse_timer = '0;
      if (pulse_hi) begin
        pulse_hi = 1'b0;
        return 1'b0;
      end
      pulse_hi = 1'b1;
      return 1'b1;
    end
    pulse_timer = nxt[15:0];
    return 1'b0;
  endfunction

  function automatic void begin_move(logic [1:0] ph);
    seq_phase = ph;
    pulse_count = '0;
    pulse_hi = 1'b1;
    pulse_timer = '0;
  endfunction

  // Queue the pins seen during this tick, then advance the sequence.
  function automatic void predict_pin_state(logic with_tick);
    pin_state_t pins;
    items_sent++;
    if (!with_tick) idle_items++;
    // A due jog starts first, so its tick already shows the step high.
    if (with_tick && seq_phase == PH_FINAL_PAUSE && !jog_on &&
        (jog_due || timer_done(jog_count, set_jog_gap))) begin
      jog_on = 1'b1;
      jog_due = 1'b0;
      jog_fwd = !jog_fwd;
      pulse_hi = 1'b1;
      pulse_timer = '0;
      jogs_done++;
    end
    pins.pos = pos_count;
    pins.ph = seq_phase;
    case (seq_phase)
      PH_FWD_MOVE: begin
        pins.step = pulse_hi;
        pins.dir = 1'b1;
      end
      PH_PAUSE: begin
        pins.step = 1'b0;
        pins.dir = 1'b1;
      end
      PH_REV_MOVE: begin
        pins.step = pulse_hi;
        pins.dir = 1'b0;
      end
      default: begin
        pins.step = jog_on && pulse_hi;
        pins.dir = jog_fwd;
      end
    endcase
    pin_state_q.push_back(pins);
    if (!with_tick) return;

    case (seq_phase)
      PH_FWD_MOVE, PH_REV_MOVE: begin
        if (pulse_advance()) begin
          pos_count = (seq_phase == PH_FWD_MOVE) ? pos_count + 32'd1 : pos_count - 32'd1;
          pulse_count = pulse_count + 16'd1;
          if (pulse_count >= set_pulses || pulse_count == 16'd0) begin
            seq_phase = (seq_phase == PH_FWD_MOVE) ? PH_PAUSE : PH_FINAL_PAUSE;
            pause_count = '0;
            if (seq_phase == PH_FINAL_PAUSE) jog_due = 1'b1;
          end
        end
      end
      PH_PAUSE: begin
        pause_count = timer_inc(pause_count);
        if (timer_done(pause_count, set_pause_pre)) begin_move(PH_REV_MOVE);
      end
      default: begin
        pause_count = timer_inc(pause_count);
        if (jog_on) begin
          if (pulse_advance()) begin
            pos_count = jog_fwd ? pos_count + 32'd1 : pos_count - 32'd1;
            jog_on = 1'b0;
            jog_count = '0;
          end
        end else begin
          jog_count = timer_inc(jog_count);
        end
        // The final pause never ends in the middle of a jog.
        if (!jog_on && timer_done(pause_count, set_pause_post)) begin
          begin_move(PH_FWD_MOVE);
          cycles_done++;
        end
      end
    endcase
  endfunction

  // Mostly small values, now and then a full-width one.
  function automatic cfg_data_t pick_setting(int unsigned top);
    return ($urandom_range(0, 19) == 0) ? cfg_data_t'($urandom()) :
                                          cfg_data_t'($urandom_range(0, top));
  endfunction

  // Send one tick transaction after a random gap.
  task automatic send_tick(input logic with_tick);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick <= with_tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pin_state(with_tick);
  endtask

  // Stop sending and wait until every predicted pin state has been checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pin_state_q.size() != 0) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high for a following write.
  task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    writes_done++;
    case (idx)
      REG_STEP_HIGH:    set_high = data[9:0];
      REG_STEP_LOW:     set_low = data[15:0];
      REG_PULSES:       set_pulses = data[15:0];
      REG_PAUSE_BEFORE: set_pause_pre = data;
      REG_PAUSE_AFTER:  set_pause_post = data;
      REG_JOG_INTERVAL: set_jog_gap = data;
      default: ;
    endcase
  endtask

  // Write all six registers plus one index past the list, with the block idle.
  task automatic load_settings(input cfg_data_t high_t, input cfg_data_t low_t,
                               input cfg_data_t pulses, input cfg_data_t pause_pre,
                               input cfg_data_t pause_post, input cfg_data_t jog_gap);
    wait_for_results();
    write_register(REG_STEP_HIGH, high_t);
    write_register(REG_STEP_LOW, low_t);
    write_register(REG_PULSES, pulses);
    write_register(REG_PAUSE_BEFORE, pause_pre);
    write_register(REG_PAUSE_AFTER, pause_post);
    write_register(REG_JOG_INTERVAL, jog_gap);
    write_register(FIRST_UNUSED_REG + cfg_index_t'($urandom_range(0, 1)),
                   cfg_data_t'($urandom()));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // First ticks at the reset settings, with some empty transactions.
  task automatic test_reset_settings();
    logic pattern [8] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    foreach (pattern[i]) send_tick(pattern[i]);
  endtask

  // All-ones writes are masked to width; zero settings act as one tick
  // or one pulse, so a full cycle with a jog and a zero pause runs quickly.
  task automatic test_register_extremes();
    load_settings('1, '1, '1, '1, '1, '1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    load_settings('0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 14; i++) send_tick(i != 5);
  endtask

  // Segments with random short settings and random idling on both sides.
  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned seg_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      load_settings(pick_setting(3), pick_setting(3), pick_setting(4),
                    pick_setting(6), pick_setting(8), pick_setting(5));
      gaps_on = 1'($urandom_range(0, 1));
      stalls_on = 1'($urandom_range(0, 1));
      seg_len = $urandom_range(60, 140);
      for (int unsigned k = 0; k < seg_len; k++) send_tick($urandom_range(0, 99) < 85);
      sent += seg_len;
    end
  endtask

  // Result back pressure: a random stall before each transaction.
  initial begin : result_backpressure
    int unsigned hold;
    forever begin
      hold = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pin_state_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: step %0b dir %0b position %0d phase %0d",
                   step_level, dir_level, position, phase);
      end else begin
        want_pins = pin_state_q.pop_front();
        if (step_level !== want_pins.step || dir_level !== want_pins.dir ||
            position !== want_pins.pos || phase !== want_pins.ph) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: expected step %0b dir %0b position %0d phase %0d,",
                      " got %0b %0b %0d %0d"},
                     want_pins.step, want_pins.dir, want_pins.pos, want_pins.ph,
                     step_level, dir_level, position, phase);
        end
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    tick <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_STEP_HIGH;
    cfg_data <= '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    mismatch_count = 0;
    items_sent = 0;
    idle_items = 0;
    writes_done = 0;
    cycles_done = 0;
    jogs_done = 0;

    // Predictor starts from the reset state.
    set_high = STEP_HIGH_RESET;
    set_low = STEP_LOW_RESET;
    set_pulses = PULSES_RESET;
    set_pause_pre = PAUSE_BEFORE_RESET;
    set_pause_post = PAUSE_AFTER_RESET;
    set_jog_gap = JOG_INTERVAL_RESET;
    seq_phase = PH_FWD_MOVE;
    pulse_hi = 1'b1;
    pulse_timer = '0;
    pulse_count = '0;
    pause_count = '0;
    jog_count = '0;
    jog_on = 1'b0;
    jog_due = 1'b1;
    jog_fwd = 1'b0;
    pos_count = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_register_extremes();
    test_random_sequences();

    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Covered %0d tick transactions (%0d without time passing) and %0d register writes,",
             items_sent, idle_items, writes_done);
    $display("with %0d complete move cycles and %0d jog pulses; %0d mismatches.",
             cycles_done, jogs_done, mismatch_count);
    if (mismatch_count == 0 && pin_state_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
